// File: rtl/cti_pkg.sv
package cti_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;

   localparam int KEY_W    = 15;
   localparam int VALUE_W  = 16;
   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 4;
   localparam int LEN_W    = 5;
   localparam int QUOT_W   = 16;
   localparam int PROD_W   = KEY_W + QUOT_W;
   localparam int DCNT_W   = $clog2(QUOT_W);

   localparam logic [LEN_W-1:0] TABLE_LENGTH_RESET = LEN_W'(16);

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INTERP = 2'd0,
      STATUS_FIRST  = 2'd1,
      STATUS_LAST   = 2'd2
   } range_status_type;

   typedef struct packed {
      logic             write;
      logic             start;
      logic             read;
      logic             advance;
      logic             mul;
      logic             div_init;
      logic             div_step;
      logic             out_load;
      range_status_type out_status;
   } cti_cmd_type;

   typedef struct packed {
      logic key_below;
      logic first;
      logic last;
      logic div_last;
   } cti_status_type;

endpackage

// File: rtl/cti_datapath.sv
module cti_datapath
   import cti_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cti_cmd_type                cmd,
   output cti_status_type             status,
   input  logic [INDEX_W-1:0]         req_entry_index,
   input  logic [KEY_W-1:0]           req_entry_key,
   input  logic signed [VALUE_W-1:0]  req_entry_value,
   input  logic [SAMPLE_W-1:0]        req_sample,
   input  logic                       csr_write_enable,
   input  logic [LEN_W-1:0]           csr_write_data,
   output logic signed [VALUE_W-1:0]  rsp_converted_value,
   output logic [1:0]                 rsp_range_status
);

   localparam int AW = $clog2(TABLE_ENTRIES);

   logic [KEY_W-1:0]   key_mem   [TABLE_ENTRIES];
   logic [VALUE_W-1:0] value_mem [TABLE_ENTRIES];

   logic [LEN_W-1:0]    table_length_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [AW-1:0]       idx_ff;
   logic [AW-1:0]       last_idx_ff;
   logic [AW-1:0]       last_idx_in;
   logic [KEY_W-1:0]    key_rd_ff;
   logic [VALUE_W-1:0]  val_rd_ff;
   logic [KEY_W-1:0]    prev_key_ff;
   logic [VALUE_W-1:0]  prev_val_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [KEY_W-1:0]    dn_ff;
   logic                neg_ff;
   logic [VALUE_W-1:0]  base_ff;
   logic [KEY_W-1:0]    rem_ff;
   logic [QUOT_W-1:0]   quot_ff;
   logic [DCNT_W-1:0]   div_cnt_ff;
   logic [VALUE_W-1:0]  out_value_ff;
   logic [1:0]          out_status_ff;

   logic                wr_in_range;
   logic [VALUE_W:0]    dv;
   logic [VALUE_W:0]    dv_mag;
   logic [KEY_W-1:0]    a_diff;
   logic [KEY_W-1:0]    d_diff;
   logic [PROD_W-1:0]   prod;
   logic [KEY_W:0]      trial;
   logic                q_bit;
   logic [VALUE_W-1:0]  interp;

   assign wr_in_range = 32'(req_entry_index) < 32'(TABLE_ENTRIES);

   always_comb begin
      if (table_length_ff == '0) begin
         last_idx_in = '0;
      end else if (32'(table_length_ff) > 32'(TABLE_ENTRIES)) begin
         last_idx_in = AW'(TABLE_ENTRIES - 1);
      end else begin
         last_idx_in = AW'(table_length_ff - LEN_W'(1));
      end
   end

   // Keys before the match lie at or above the sample, so both differences are
   // non-negative and the division works on magnitudes only.
   assign dv     = {val_rd_ff[VALUE_W-1], val_rd_ff} - {prev_val_ff[VALUE_W-1], prev_val_ff};
   assign dv_mag = dv[VALUE_W] ? (~dv + 1'b1) : dv;
   assign a_diff = prev_key_ff - sample_ff[KEY_W-1:0];
   assign d_diff = prev_key_ff - key_rd_ff;
   assign prod   = {{KEY_W{1'b0}}, dv_mag[VALUE_W-1:0]} * {{QUOT_W{1'b0}}, a_diff};

   assign trial  = {rem_ff, quot_ff[QUOT_W-1]};
   assign q_bit  = trial >= {1'b0, dn_ff};
   assign interp = base_ff + (neg_ff ? (~quot_ff + 1'b1) : quot_ff);

   assign status.key_below = {1'b0, key_rd_ff} < sample_ff;
   assign status.first     = idx_ff == '0;
   assign status.last      = idx_ff == last_idx_ff;
   assign status.div_last  = div_cnt_ff == DCNT_W'(QUOT_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= TABLE_LENGTH_RESET;
      end else if (csr_write_enable) begin
         table_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_in_range) begin
         key_mem[AW'(req_entry_index)]   <= req_entry_key;
         value_mem[AW'(req_entry_index)] <= req_entry_value;
      end
      if (cmd.read) begin
         key_rd_ff <= key_mem[idx_ff];
         val_rd_ff <= value_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sample_ff   <= req_sample;
         idx_ff      <= '0;
         last_idx_ff <= last_idx_in;
      end else if (cmd.advance) begin
         idx_ff      <= idx_ff + AW'(1);
         prev_key_ff <= key_rd_ff;
         prev_val_ff <= val_rd_ff;
      end
      if (cmd.mul) begin
         prod_ff <= prod;
         dn_ff   <= d_diff;
         neg_ff  <= dv[VALUE_W];
         base_ff <= prev_val_ff;
      end
      if (cmd.div_init) begin
         rem_ff     <= prod_ff[PROD_W-1:QUOT_W];
         quot_ff    <= prod_ff[QUOT_W-1:0];
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= q_bit ? KEY_W'(trial - {1'b0, dn_ff}) : trial[KEY_W-1:0];
         quot_ff    <= {quot_ff[QUOT_W-2:0], q_bit};
         div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
      end
      if (cmd.out_load) begin
         out_value_ff  <= (cmd.out_status == STATUS_INTERP) ? interp : val_rd_ff;
         out_status_ff <= cmd.out_status;
      end
   end

   assign rsp_converted_value = out_value_ff;
   assign rsp_range_status    = out_status_ff;

endmodule

// File: rtl/cti_ctrl.sv
module cti_ctrl
   import cti_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_cmd,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  cti_status_type status,
   output cti_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      FETCH,
      TEST,
      MUL,
      DIV_INIT,
      DIV,
      FINISH
   } state_type;

   state_type        state_ff, state_in;
   range_status_type code_ff, code_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd            = '0;
      cmd.out_status = code_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = FETCH;
               end
            end
         end
         FETCH: begin
            cmd.read = 1'b1;
            state_in = TEST;
         end
         TEST: begin
            if (status.key_below) begin
               if (status.first) begin
                  code_in  = STATUS_FIRST;
                  state_in = FINISH;
               end else begin
                  code_in  = STATUS_INTERP;
                  state_in = MUL;
               end
            end else if (status.last) begin
               code_in  = STATUS_LAST;
               state_in = FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = FETCH;
            end
         end
         MUL: begin
            cmd.mul  = 1'b1;
            state_in = DIV_INIT;
         end
         DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         code_ff      <= STATUS_INTERP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/calibration_table_interpolator_unit.sv
// Converts raw sensor readings through a calibration table of key and value
// pairs held in descending key order.
// Input channel (req_*): a word with req_cmd low writes req_entry_key and
// req_entry_value at req_entry_index and gives no result; a word with req_cmd
// high looks up req_sample and gives one result word on the rsp_* channel.
// Configuration: csr_write_enable loads csr_write_data into the table length.
// A lookup that matches at table entry m searches entries 0 to m, one table
// read and one compare per entry, and then either clamps or interpolates,
// using a multiply step, a divider load and a restoring divider that forms
// the quotient bit by bit. The next word is taken once the result sits in
// the output register.
// A finished result waits in the output register while rsp_ready is low; a
// write word is still taken meanwhile, but a second lookup holds in its last
// step until the pending result is taken.
// Reset clears the control state and the pending result and sets the table
// length to 16. Table entries are undefined until written.
module calibration_table_interpolator_unit
   import cti_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [INDEX_W-1:0]         req_entry_index,
   input  logic [KEY_W-1:0]           req_entry_key,
   input  logic signed [VALUE_W-1:0]  req_entry_value,
   input  logic [SAMPLE_W-1:0]        req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_converted_value,
   output logic [1:0]                 rsp_range_status,
   input  logic                       csr_write_enable,
   input  logic [LEN_W-1:0]           csr_write_data
);

   cti_cmd_type    cmd;
   cti_status_type status;

   cti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cti_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_entry_index     (req_entry_index),
      .req_entry_key       (req_entry_key),
      .req_entry_value     (req_entry_value),
      .req_sample          (req_sample),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_converted_value (rsp_converted_value),
      .rsp_range_status    (rsp_range_status)
   );

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (req_valid && req_ready))
      else $error("table write outside an accepted word");

   a_start_fetches: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (cmd.read && !req_ready))
      else $error("lookup did not begin with a table read");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> !cmd.div_step)
      else $error("divider ran past its last step");
`endif

endmodule
